// ===== sv/acsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsm_pkg
// Shared types and constants for the axle counter section monitor.
// ----------------------------------------------------------------------------
package acsm_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TickW  = 16;

  localparam logic [TickW-1:0] PreTicksDefault   = 16'd3000;
  localparam logic [TickW-1:0] ResetTicksDefault = 16'd10000;

  typedef enum logic [2:0] {
    MODE_OCC_START  = 3'd0,
    MODE_RESET_PRE  = 3'd1,
    MODE_RESET      = 3'd2,
    MODE_RESET_POST = 3'd3,
    MODE_FREE       = 3'd4,
    MODE_OCCUPIED   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    KIND_AXLE  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_POWER = 2'd2,
    KIND_TICK  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_INVERT_A   = 2'd0,
    REG_INVERT_B   = 2'd1,
    REG_PRE_TICKS  = 2'd2,
    REG_RESET_TICKS = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     sensor_select;
    logic signed [CountW-1:0] axle_delta;
    logic                     level;
  } item_t;

  typedef struct packed {
    logic [2:0]               section_state;
    logic signed [CountW-1:0] axle_total;
    logic                     changed;
  } result_t;

  typedef struct packed {
    logic             invert_sensor_a;
    logic             invert_sensor_b;
    logic [TickW-1:0] pre_reset_ticks;
    logic [TickW-1:0] reset_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [CountW-1:0] count;
    logic [TickW-1:0]         countdown;
    logic                     powered;
  } sect_state_t;

endpackage

// ===== sv/axle_counter_section_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axle_counter_section_monitor
// Track-section axle counter evaluator with timed reset sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Events (axle deltas, reset line, power level, 1 ms ticks) enter on the
//   in_* channel; each produces exactly one result on out_* carrying the
//   section state, the saturated axle total and a changed flag.
//   An event is registered on transfer and evaluated against the section
//   state while it sits in the input register; the result register loads
//   it when out_stall does not hold the result register, and out_* then
//   offers it. One event per cycle is sustained while out_stall stays low; the
//   state update is a single add, clamp and mode select per cycle.
//   When out_stall holds the result register, the input register keeps one
//   more event and in_stall rises only once both are full.
//   Configuration writes go through cfg_valid/cfg_ready (always ready) and
//   should be made while no events are in flight.
//   Synchronous reset empties both registers, restores the default
//   configuration and puts the section into occupied-at-start, count zero,
//   unpowered.
// ----------------------------------------------------------------------------
module axle_counter_section_monitor (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  acsm_pkg::item_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output acsm_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import acsm_pkg::*;

  cfg_t        cfg;
  sect_state_t st;
  sect_state_t st_next;
  item_t       item_q;
  logic        item_valid;
  logic        advance;
  logic        fire;
  logic        changed_next;

  assign advance   = !out_valid || !out_stall;
  assign fire      = item_valid && advance;
  assign in_stall  = item_valid && !advance;
  assign cfg_ready = 1'b1;

  acsm_eval u_eval (
    .cur     (st),
    .cfg     (cfg),
    .item    (item_q),
    .nxt     (st_next),
    .changed (changed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.invert_sensor_a <= 1'b0;
      cfg.invert_sensor_b <= 1'b1;
      cfg.pre_reset_ticks <= PreTicksDefault;
      cfg.reset_ticks     <= ResetTicksDefault;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_INVERT_A:    cfg.invert_sensor_a <= cfg_data[0];
        REG_INVERT_B:    cfg.invert_sensor_b <= cfg_data[0];
        REG_PRE_TICKS:   cfg.pre_reset_ticks <= cfg_data;
        REG_RESET_TICKS: cfg.reset_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refill whenever its contents move on or it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode      <= MODE_OCC_START;
      st.count     <= '0;
      st.countdown <= '0;
      st.powered   <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.section_state <= st_next.mode;
      out_data.axle_total    <= st_next.count;
      out_data.changed       <= changed_next;
    end
  end

endmodule

// ===== sv/acsm_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acsm_eval
// Next-state logic: applies one event to the section state and reports
// whether the visible state or count moved.
// ----------------------------------------------------------------------------
module acsm_eval (
  input  acsm_pkg::sect_state_t cur,
  input  acsm_pkg::cfg_t        cfg,
  input  acsm_pkg::item_t       item,
  output acsm_pkg::sect_state_t nxt,
  output logic                  changed
);
  import acsm_pkg::*;

  logic                     in_reset;
  logic                     inv;
  logic signed [CountW:0]   delta_ext;
  logic signed [CountW+1:0] sum;
  logic signed [CountW-1:0] sat;
  logic [TickW-1:0]         cd_dec;
  logic [TickW-1:0]         pre_load;
  logic [TickW-1:0]         rst_load;
  mode_t                    target;
  mode_t                    settled;

  assign in_reset = (cur.mode == MODE_RESET_PRE) || (cur.mode == MODE_RESET) ||
                    (cur.mode == MODE_RESET_POST);
  assign inv      = item.sensor_select ? cfg.invert_sensor_b : cfg.invert_sensor_a;

  // Widen before negating so the most negative delta flips cleanly.
  assign delta_ext = inv ? -{item.axle_delta[CountW-1], item.axle_delta}
                         :  {item.axle_delta[CountW-1], item.axle_delta};
  assign sum = {{2{cur.count[CountW-1]}}, cur.count} +
               {delta_ext[CountW], delta_ext};

  always_comb begin
    if (sum > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[CountW-1:0];
    end
  end

  assign settled  = (cur.count == '0) ? MODE_FREE : MODE_OCCUPIED;
  assign cd_dec   = cur.countdown - 1'b1;
  assign pre_load = (cfg.pre_reset_ticks == '0) ? TickW'(1) : cfg.pre_reset_ticks;
  assign rst_load = (cfg.reset_ticks == '0) ? TickW'(1) : cfg.reset_ticks;

  always_comb begin
    nxt    = cur;
    target = cur.mode;
    unique case (kind_t'(item.kind))
      KIND_AXLE: begin
        if (cur.mode != MODE_OCC_START && !in_reset && item.axle_delta != '0) begin
          nxt.count = sat;
          target    = (sat == '0) ? MODE_FREE : MODE_OCCUPIED;
        end
      end
      KIND_RESET: begin
        if (item.level && !in_reset) begin
          target = MODE_RESET_PRE;
        end else if (!item.level && in_reset) begin
          target = (cur.powered && cur.mode == MODE_RESET) ? settled : MODE_OCC_START;
        end
      end
      KIND_POWER: begin
        if (cur.powered != item.level) begin
          nxt.powered = item.level;
          if (!in_reset) begin
            target = MODE_OCC_START;
          end
        end
      end
      KIND_TICK: begin
        if ((cur.mode == MODE_RESET_PRE || cur.mode == MODE_RESET) &&
            cur.countdown != '0) begin
          nxt.countdown = cd_dec;
          if (cd_dec == '0) begin
            target = (cur.mode == MODE_RESET_PRE) ? MODE_RESET : MODE_RESET_POST;
          end
        end
      end
      default: ;
    endcase

    // Entering a mode clears the count where required and loads the timer.
    if (target != cur.mode) begin
      nxt.mode = target;
      if (target == MODE_OCC_START || target == MODE_RESET_PRE ||
          target == MODE_RESET || target == MODE_RESET_POST) begin
        nxt.count = '0;
      end
      if (target == MODE_RESET_PRE) begin
        nxt.countdown = pre_load;
      end else if (target == MODE_RESET) begin
        nxt.countdown = rst_load;
      end
    end
  end

  assign changed = (nxt.mode != cur.mode) || (nxt.count != cur.count);

endmodule

// ===== test/axle_counter_section_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axle_counter_section_monitor_tb
// Self-checking bench for the axle counter section monitor. A queue-fed
// driver sends events, a clocked monitor compares every result against an
// in-bench model of the section, and register settings change between phases.
// ----------------------------------------------------------------------------
module axle_counter_section_monitor_tb;
  import acsm_pkg::*;

  localparam int CycleLimit    = 50_000;
  localparam int RandomPhases  = 8;
  localparam int ItemsPerPhase = 150;
  localparam int MaxPrinted    = 40;
  localparam int ItemW         = $bits(item_t);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  item_t             in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  result_t           out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  // section model
  mode_t             sec_mode = MODE_OCC_START;
  logic signed [15:0] sec_count = '0;
  logic [15:0]       sec_countdown = '0;
  logic              sec_powered = 1'b0;
  logic              cfg_inv_a = 1'b0;
  logic              cfg_inv_b = 1'b1;
  logic [15:0]       cfg_pre_ticks = PreTicksDefault;
  logic [15:0]       cfg_reset_ticks = ResetTicksDefault;

  item_t             pending_items[$];
  result_t           expected_results[$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                cycle_count = 0;
  int                items_sent = 0;
  int                results_checked = 0;
  int                reg_writes = 0;
  int                mismatches = 0;
  int                queued_items = 0;

  axle_counter_section_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("axle_counter_section_monitor verification failed");
      $finish;
    end
  end

  function automatic int tick_load(logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  function automatic bit resetting();
    return sec_mode == MODE_RESET_PRE || sec_mode == MODE_RESET ||
           sec_mode == MODE_RESET_POST;
  endfunction

  function automatic mode_t count_mode();
    return (sec_count == 16'sd0) ? MODE_FREE : MODE_OCCUPIED;
  endfunction

  function automatic void move_to(mode_t nxt);
    if (nxt == sec_mode) return;
    sec_mode = nxt;
    // clear the count on entering occupied-at-start or any reset state
    if (sec_mode == MODE_OCC_START || resetting()) sec_count = '0;
    if (sec_mode == MODE_RESET_PRE) sec_countdown = 16'(tick_load(cfg_pre_ticks));
    else if (sec_mode == MODE_RESET) sec_countdown = 16'(tick_load(cfg_reset_ticks));
  endfunction

  function automatic result_t next_section_result(item_t it);
    mode_t              prev_mode;
    logic signed [15:0] prev_count;
    int                 delta;
    int                 sum;
    logic               inv;
    result_t            res;
    prev_mode = sec_mode;
    prev_count = sec_count;
    case (kind_t'(it.kind))
      KIND_AXLE: begin
        delta = int'($signed(it.axle_delta));
        if (sec_mode != MODE_OCC_START && !resetting() && delta != 0) begin
          inv = it.sensor_select ? cfg_inv_b : cfg_inv_a;
          if (inv) delta = -delta;
          sum = int'(sec_count) + delta;
          if (sum > 32767) sum = 32767;
          else if (sum < -32768) sum = -32768;
          sec_count = 16'(sum);
          move_to(count_mode());
        end
      end
      KIND_RESET: begin
        if (it.level && !resetting()) begin
          move_to(MODE_RESET_PRE);
        end else if (!it.level && resetting()) begin
          if (sec_powered && sec_mode == MODE_RESET) move_to(count_mode());
          else move_to(MODE_OCC_START);
        end
      end
      KIND_POWER: begin
        if (sec_powered != it.level) begin
          sec_powered = it.level;
          if (!resetting()) move_to(MODE_OCC_START);
        end
      end
      default: begin
        if ((sec_mode == MODE_RESET_PRE || sec_mode == MODE_RESET) && sec_countdown != 0) begin
          sec_countdown = sec_countdown - 16'd1;
          if (sec_countdown == 0)
            move_to(sec_mode == MODE_RESET_PRE ? MODE_RESET : MODE_RESET_POST);
        end
      end
    endcase
    res.section_state = sec_mode;
    res.axle_total = sec_count;
    res.changed = (sec_mode != prev_mode) || (sec_count != prev_count);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: result %0d %s got %h, expected %h", $realtime, results_checked,
               field, got, want);
  endtask

  // driver: advance on a transfer or while idle, hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(next_section_result(in_data));
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: %p", $realtime, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.section_state !== want.section_state)
            report_mismatch("section_state", 16'(out_data.section_state),
                            16'(want.section_state));
          if (out_data.axle_total !== want.axle_total)
            report_mismatch("axle_total", out_data.axle_total, want.axle_total);
          if (out_data.changed !== want.changed)
            report_mismatch("changed", 16'(out_data.changed), 16'(want.changed));
          results_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_item(kind_t k, logic sel, logic signed [15:0] d, logic lvl);
    item_t it;
    it.kind = k;
    it.sensor_select = sel;
    it.axle_delta = d;
    it.level = lvl;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic add_ticks(int n);
    for (int i = 0; i < n; i++) add_item(KIND_TICK, 1'b0, '0, 1'b0);
  endtask

  function automatic logic signed [15:0] pick_delta();
    case ($urandom_range(6))
      0: return 16'sd0;
      1: return 16'sd32767;
      2: return 16'sh8000;
      3: return 16'($urandom_range(1, 20));
      4: return 16'(-int'($urandom_range(1, 20)));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_INVERT_A:  cfg_inv_a = val[0];
      REG_INVERT_B:  cfg_inv_b = val[0];
      REG_PRE_TICKS: cfg_pre_ticks = val;
      default:       cfg_reset_ticks = val;
    endcase
  endtask

  task automatic set_all_regs(logic inv_a, logic inv_b, logic [15:0] pre, logic [15:0] rst_t);
    write_reg(REG_INVERT_A, 16'(inv_a));
    write_reg(REG_INVERT_B, 16'(inv_b));
    write_reg(REG_PRE_TICKS, pre);
    write_reg(REG_RESET_TICKS, rst_t);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_traffic(int sel);
    case (sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 17; recv_stall_pct = 17; end
    endcase
  endtask

  // reset request, countdown ticks, a release in most runs, then a burst of axle traffic
  task automatic add_section_run();
    int pre_n;
    int rst_n;
    int nt;
    pre_n = tick_load(cfg_pre_ticks);
    rst_n = tick_load(cfg_reset_ticks);
    if ($urandom_range(3) == 0) add_item(KIND_POWER, 1'($urandom), 16'($urandom), 1'b1);
    add_item(KIND_RESET, 1'($urandom), 16'($urandom), 1'b1);
    if (pre_n > 64 || rst_n > 64) nt = $urandom_range(0, 8);
    else if ($urandom_range(9) < 8) nt = pre_n + $urandom_range(0, rst_n - 1);
    else nt = $urandom_range(0, pre_n + rst_n + 1);
    for (int i = 0; i < nt; i++)
      add_item(KIND_TICK, 1'($urandom), 16'($urandom), 1'($urandom));
    if ($urandom_range(7) != 0) add_item(KIND_RESET, 1'($urandom), 16'($urandom), 1'b0);
    repeat ($urandom_range(0, 12))
      add_item(KIND_AXLE, 1'($urandom), pick_delta(), 1'($urandom));
  endtask

  task automatic add_noise();
    logic [ItemW-1:0] raw;
    repeat ($urandom_range(1, 4)) begin
      raw = ItemW'($urandom);
      pending_items.push_back(item_t'(raw));
      queued_items++;
    end
  endtask

  initial begin
    int start_count;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default timing and inversion, reset released during the pre phase
    set_traffic(0);
    add_item(KIND_POWER, 1'b0, '0, 1'b1);
    add_item(KIND_RESET, 1'b0, '0, 1'b1);
    add_ticks(6);
    add_item(KIND_RESET, 1'b0, '0, 1'b0);
    add_item(KIND_AXLE, 1'b1, 16'sd3, 1'b0);
    add_item(KIND_AXLE, 1'b0, 16'sd3, 1'b0);
    drain();

    // directed walk; zero reset timing behaves as one tick
    set_all_regs(1'b1, 1'b0, 16'd2, 16'd0);
    @(negedge clk);
    add_item(KIND_POWER, 1'b0, '0, 1'b0);
    add_item(KIND_AXLE, 1'b0, 16'sd5, 1'b1);
    add_item(KIND_TICK, 1'b1, 16'sh7fff, 1'b1);
    add_item(KIND_RESET, 1'b1, 16'sh8000, 1'b0);
    add_item(KIND_POWER, 1'b0, '0, 1'b1);
    add_item(KIND_POWER, 1'b0, '0, 1'b1);
    add_item(KIND_RESET, 1'b0, '0, 1'b1);
    add_item(KIND_RESET, 1'b0, '0, 1'b1);
    add_item(KIND_AXLE, 1'b1, 16'sd7, 1'b0);
    add_item(KIND_POWER, 1'b0, '0, 1'b0);
    add_item(KIND_POWER, 1'b0, '0, 1'b1);
    add_ticks(4);
    add_item(KIND_RESET, 1'b0, '0, 1'b0);
    add_item(KIND_RESET, 1'b0, '0, 1'b1);
    add_ticks(3);
    add_item(KIND_RESET, 1'b0, '0, 1'b0);
    add_item(KIND_AXLE, 1'b0, 16'sd32767, 1'b0);
    add_item(KIND_AXLE, 1'b1, 16'sh8000, 1'b1);
    add_item(KIND_AXLE, 1'b1, 16'sd0, 1'b0);
    add_item(KIND_AXLE, 1'b0, 16'sh8000, 1'b0);
    add_item(KIND_AXLE, 1'b1, 16'sd32767, 1'b0);
    add_item(KIND_POWER, 1'b0, '0, 1'b0);
    drain();

    // widest timing values
    set_all_regs(1'b0, 1'b1, 16'hffff, 16'hffff);
    @(negedge clk);
    add_item(KIND_POWER, 1'b0, '0, 1'b1);
    add_item(KIND_RESET, 1'b0, '0, 1'b1);
    add_ticks(8);
    add_item(KIND_RESET, 1'b0, '0, 1'b0);
    add_item(KIND_AXLE, 1'b1, 16'sh8000, 1'b0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      set_all_regs(1'($urandom), 1'($urandom),
                   ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom_range(0, 5)),
                   ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom_range(0, 5)));
      @(negedge clk);
      set_traffic(p % 4);
      start_count = queued_items;
      add_item(KIND_POWER, 1'b0, '0, 1'b1);
      while (queued_items - start_count < ItemsPerPhase) begin
        if ($urandom_range(99) < 75) add_section_run();
        else add_noise();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("ran %0d events through %0d register writes and %0d traffic phases",
             items_sent, reg_writes, RandomPhases + 3);
    $display("checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("axle_counter_section_monitor verification clean");
    end else begin
      $display("axle_counter_section_monitor verification failed");
    end
    $finish;
  end

endmodule
